### rtl/core/bhc_pkg.sv
// Shared types and constants for the button hold classifier with LED cue.
`default_nettype none

package bhc_pkg;

    // Widths of the counters and registers
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned BLINK_W = 4;
    localparam int unsigned CFG_IDX_W = 3;

    // Mode of the classifier, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_HOLD    = 6'b000010,
        MODE_INTRO   = 6'b000100,
        MODE_WAKE    = 6'b001000,
        MODE_DFU     = 6'b010000,
        MODE_WAITREL = 6'b100000
    } t_mode;

    // Event codes on the outcome field
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_REJECT = 2'd1,
        EV_WAKE   = 2'd2,
        EV_DFU    = 2'd3
    } t_event;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DFU_MS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ON_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_OFF_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ON_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_OFF_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTRO_BLINKS = 3'd6;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0]  RST_COMMIT_MS    = 16'd3000;
    localparam logic [TIME_W-1:0]  RST_DFU_MS       = 16'd10000;
    localparam logic [TIME_W-1:0]  RST_SLOW_ON_MS   = 16'd50;
    localparam logic [TIME_W-1:0]  RST_SLOW_OFF_MS  = 16'd450;
    localparam logic [TIME_W-1:0]  RST_FAST_ON_MS   = 16'd50;
    localparam logic [TIME_W-1:0]  RST_FAST_OFF_MS  = 16'd50;
    localparam logic [BLINK_W-1:0] RST_INTRO_BLINKS = 4'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

`default_nettype wire

### rtl/core/button_hold_classifier_led_cue.sv
// Button hold classifier: measures a press per millisecond tick and drives the LED cue.
//
//  channel   direction  handshake            payload
//  tick      in         i_valid / o_stall    i_button_pressed
//  result    out        o_valid / i_stall    o_led_red, o_led_green, o_led_blue,
//                                            o_outcome, o_hold_ms
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One tick request is taken per clock; its result appears in the output register
// on the next cycle. The state update and result are one pass of counter/compare logic.
// While the result register is full and stalled, o_stall is high and ticks wait.
// Synchronous active-low reset returns to idle with the default timing registers.
`default_nettype none

module button_hold_classifier_led_cue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tick channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_button_pressed,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_led_red,
    output logic                               o_led_green,
    output logic                               o_led_blue,
    output logic [1:0]                         o_outcome,
    output logic [bhc_pkg::TIME_W-1:0]         o_hold_ms,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [bhc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bhc_pkg::TIME_W-1:0]    i_cfg_data
);
    import bhc_pkg::*;

    // Configuration registers
    logic [TIME_W-1:0]  r_commit_ms, r_dfu_ms;
    logic [TIME_W-1:0]  r_slow_on_ms, r_slow_off_ms, r_fast_on_ms, r_fast_off_ms;
    logic [BLINK_W-1:0] r_intro_blinks;

    // Classifier state
    t_mode              r_mode, n_mode;
    logic [TIME_W-1:0]  r_hold_count, n_hold_count;
    logic               r_commit_seen, n_commit_seen;
    logic [TIME_W-1:0]  r_phase_count, n_phase_count;
    logic [BLINK_W-1:0] r_blink_index, n_blink_index;
    logic               r_released, n_released;
    logic               r_lit, n_lit;

    // Result register
    logic               r_valid;
    logic               r_red, r_green, r_blue;
    t_event             r_outcome;
    logic [TIME_W-1:0]  r_hold_ms;

    logic               n_red, n_green, n_blue;
    t_event             n_outcome;
    logic [TIME_W-1:0]  n_hold_ms;

    logic               in_take;
    logic [TIME_W-1:0]  hold_inc;
    logic [TIME_W-1:0]  blink_len;
    logic [TIME_W-1:0]  phase_inc;
    logic               phase_end;
    logic               blink_wrap;
    logic [BLINK_W-1:0] blink_index_inc;

    // Take a request when the result register is free or draining
    assign o_stall = r_valid & i_stall;
    assign in_take = i_valid & ~o_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit_ms    <= RST_COMMIT_MS;
            r_dfu_ms       <= RST_DFU_MS;
            r_slow_on_ms   <= RST_SLOW_ON_MS;
            r_slow_off_ms  <= RST_SLOW_OFF_MS;
            r_fast_on_ms   <= RST_FAST_ON_MS;
            r_fast_off_ms  <= RST_FAST_OFF_MS;
            r_intro_blinks <= RST_INTRO_BLINKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COMMIT_MS:    r_commit_ms    <= i_cfg_data;
                CFG_DFU_MS:       r_dfu_ms       <= i_cfg_data;
                CFG_SLOW_ON_MS:   r_slow_on_ms   <= i_cfg_data;
                CFG_SLOW_OFF_MS:  r_slow_off_ms  <= i_cfg_data;
                CFG_FAST_ON_MS:   r_fast_on_ms   <= i_cfg_data;
                CFG_FAST_OFF_MS:  r_fast_off_ms  <= i_cfg_data;
                CFG_INTRO_BLINKS: r_intro_blinks <= i_cfg_data[BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturating hold count and shared blink phase step
    assign hold_inc = (r_hold_count == TIME_MAX) ? r_hold_count : r_hold_count + 1'b1;
    always_comb begin
        if (r_mode == MODE_WAKE) begin
            blink_len = r_lit ? r_slow_on_ms : r_slow_off_ms;
        end else begin
            blink_len = r_lit ? r_fast_on_ms : r_fast_off_ms;
        end
    end
    assign phase_inc       = r_phase_count + 1'b1;
    assign phase_end       = (phase_inc >= blink_len) || (phase_inc == '0);
    assign blink_wrap      = phase_end & ~r_lit;
    assign blink_index_inc = r_blink_index + 1'b1;

    // Next state and result for one tick
    always_comb begin
        n_mode        = r_mode;
        n_hold_count  = r_hold_count;
        n_commit_seen = r_commit_seen;
        n_phase_count = r_phase_count;
        n_blink_index = r_blink_index;
        n_released    = r_released;
        n_lit         = r_lit;
        n_red         = 1'b0;
        n_green       = 1'b0;
        n_blue        = 1'b0;
        n_outcome     = EV_NONE;
        n_hold_ms     = '0;

        unique case (r_mode)
            MODE_IDLE: begin
                if (i_button_pressed) begin
                    n_mode        = MODE_HOLD;
                    n_hold_count  = '0;
                    n_commit_seen = 1'b0;
                    n_red         = 1'b1;
                end
            end
            MODE_HOLD: begin
                n_hold_count = hold_inc;
                if (i_button_pressed) begin
                    if (hold_inc >= r_commit_ms) begin
                        n_commit_seen = 1'b1;
                    end
                    if (hold_inc >= r_dfu_ms) begin
                        n_outcome     = EV_DFU;
                        n_hold_ms     = hold_inc;
                        n_released    = 1'b0;
                        n_blink_index = '0;
                        n_mode        = (r_intro_blinks == '0) ? MODE_DFU : MODE_INTRO;
                        n_phase_count = '0;
                        n_lit         = 1'b1;
                    end else begin
                        n_red = ~(r_commit_seen | (hold_inc >= r_commit_ms));
                    end
                end else begin
                    n_hold_ms = hold_inc;
                    if (hold_inc < r_commit_ms) begin
                        n_outcome = EV_REJECT;
                        n_mode    = MODE_IDLE;
                    end else begin
                        n_outcome     = EV_WAKE;
                        n_mode        = MODE_WAKE;
                        n_phase_count = '0;
                        n_lit         = 1'b1;
                    end
                end
            end
            MODE_INTRO: begin
                if (!i_button_pressed) begin
                    n_released = 1'b1;
                end
                n_blue        = r_lit;
                n_phase_count = phase_end ? '0 : phase_inc;
                n_lit         = phase_end ? ~r_lit : r_lit;
                if (blink_wrap) begin
                    n_blink_index = blink_index_inc;
                    if (blink_index_inc >= r_intro_blinks) begin
                        n_mode        = MODE_DFU;
                        n_phase_count = '0;
                        n_lit         = 1'b1;
                    end
                end
            end
            MODE_WAKE: begin
                if (i_button_pressed) begin
                    n_mode = MODE_WAITREL;
                end else begin
                    n_green       = r_lit;
                    n_phase_count = phase_end ? '0 : phase_inc;
                    n_lit         = phase_end ? ~r_lit : r_lit;
                end
            end
            MODE_DFU: begin
                if (!i_button_pressed) begin
                    n_released = 1'b1;
                end
                if (i_button_pressed && r_released) begin
                    n_mode = MODE_WAITREL;
                end else begin
                    n_blue        = r_lit;
                    n_phase_count = phase_end ? '0 : phase_inc;
                    n_lit         = phase_end ? ~r_lit : r_lit;
                end
            end
            MODE_WAITREL: begin
                if (!i_button_pressed) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    // Advance the state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_hold_count  <= '0;
            r_commit_seen <= 1'b0;
            r_phase_count <= '0;
            r_blink_index <= '0;
            r_released    <= 1'b0;
            r_lit         <= 1'b0;
        end else if (in_take) begin
            r_mode        <= n_mode;
            r_hold_count  <= n_hold_count;
            r_commit_seen <= n_commit_seen;
            r_phase_count <= n_phase_count;
            r_blink_index <= n_blink_index;
            r_released    <= n_released;
            r_lit         <= n_lit;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_outcome <= n_outcome;
            r_hold_ms <= n_hold_ms;
        end
    end

    assign o_valid     = r_valid;
    assign o_led_red   = r_red;
    assign o_led_green = r_green;
    assign o_led_blue  = r_blue;
    assign o_outcome   = r_outcome;
    assign o_hold_ms   = r_hold_ms;

    // An event tick shows all LEDs off
    a_event_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_outcome != EV_NONE) |-> !(r_red || r_green || r_blue))
        else $error("LED lit on an event tick");

    // No hold duration without an event
    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_outcome == EV_NONE) |-> (r_hold_ms == '0))
        else $error("hold_ms set without an event");

    // At most one LED is lit
    a_one_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($countones({r_red, r_green, r_blue}) <= 1))
        else $error("more than one LED lit");

    // A dfu event always enters a blue pattern with the on half first
    a_dfu_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && n_outcome == EV_DFU) |=>
            ((r_mode == MODE_INTRO || r_mode == MODE_DFU) && r_lit && r_phase_count == '0))
        else $error("dfu event did not start the blue pattern");

    // Red is only lit while a hold is being measured
    a_red_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && n_red) |=> (r_mode == MODE_HOLD))
        else $error("red lit outside a hold");

endmodule

`default_nettype wire
